// ===== sv/gqi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqi_pkg
// Shared types, constants and term tables of the quaternion integrator.
// ----------------------------------------------------------------------------
package gqi_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] quat_t;
  typedef word_t [2:0] rates_t;

  localparam int NORM_ITERATIONS_DEF = 4;
  localparam word_t STEP_RESET = 32'd4294967;
  localparam word_t ATT_ONE = 32'h4000_0000;

  // Restoring divider widths: numerator, divisor.
  localparam int DIV_NW = 63;
  localparam int DIV_DW = 33;

  // Attitude part indexes.
  localparam logic [1:0] IDX_W = 2'd0;
  localparam logic [1:0] IDX_X = 2'd1;
  localparam logic [1:0] IDX_Y = 2'd2;
  localparam logic [1:0] IDX_Z = 2'd3;

  // Control bundle from the sequencer to each lane.
  typedef struct packed {
    logic       acc_clr;
    logic       term_mul;
    logic [1:0] term;
    logic       term_add;
    logic       scale_mul;
    logic       scale_sum;
    logic       update;
    logic       square;
  } lane_ctl_t;

  // Hamilton product q * (0, r): attitude part used by term k of lane j.
  function automatic logic [1:0] term_q(input int lane, input logic [1:0] k);
    logic [1:0] r;
    r = IDX_W;
    case (lane)
      0: r = (k == 2'd0) ? IDX_X : (k == 2'd1) ? IDX_Y : IDX_Z;
      1: r = (k == 2'd0) ? IDX_W : (k == 2'd1) ? IDX_Y : IDX_Z;
      2: r = (k == 2'd0) ? IDX_W : (k == 2'd1) ? IDX_X : IDX_Z;
      default: r = (k == 2'd0) ? IDX_W : (k == 2'd1) ? IDX_X : IDX_Y;
    endcase
    return r;
  endfunction

  // Rate axis (0 x, 1 y, 2 z) used by term k of lane j.
  function automatic logic [1:0] term_r(input int lane, input logic [1:0] k);
    logic [1:0] r;
    r = 2'd0;
    case (lane)
      0: r = (k == 2'd0) ? 2'd0 : (k == 2'd1) ? 2'd1 : 2'd2;
      1: r = (k == 2'd0) ? 2'd0 : (k == 2'd1) ? 2'd2 : 2'd1;
      2: r = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd2 : 2'd0;
      default: r = (k == 2'd0) ? 2'd2 : (k == 2'd1) ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

  // Whether term k of lane j is subtracted.
  function automatic logic term_neg(input int lane, input logic [1:0] k);
    logic r;
    r = 1'b0;
    case (lane)
      0: r = 1'b1;
      1: r = (k == 2'd2);
      2: r = (k == 2'd1);
      default: r = (k == 2'd2);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/gqi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gqi_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gqi_pkg::DIV_NW-1:0] num,
  input  logic [gqi_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [gqi_pkg::DIV_NW-1:0] quo
);
  import gqi_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] work;
  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [DIV_DW-1:0] rem_next;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem, work[DIV_NW-1]};
    ge = (trial >= {1'b0, den});
    rem_next = ge ? DIV_DW'(trial - {1'b0, den}) : DIV_DW'(trial);
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      work <= num;
    end else if (busy) begin
      rem <= rem_next;
      work <= {work[DIV_NW-2:0], ge};
    end
  end

  assign quo = work;

endmodule

// ===== sv/gqi_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqi_lane
// One quaternion part: derivative terms, step scaling, saturating update
// and the square that feeds the norm.
// ----------------------------------------------------------------------------
module gqi_lane #(
  parameter int LANE = 0
) (
  input  logic               clk,
  input  gqi_pkg::lane_ctl_t ctl,
  input  gqi_pkg::quat_t     att,
  input  gqi_pkg::rates_t    rates,
  input  gqi_pkg::word_t     step_time,
  output gqi_pkg::word_t     qn,
  output logic [62:0]        sq
);
  import gqi_pkg::*;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic               prod_neg;
  logic signed [38:0] term_val;
  logic signed [41:0] acc;
  logic signed [58:0] ph;
  logic signed [58:0] pl;
  logic signed [58:0] ssum;
  logic signed [42:0] scaled;
  logic signed [43:0] tot;
  word_t              sat;

  // Multiplier operands: a derivative term or the updated part squared.
  always_comb begin
    if (ctl.square) begin
      mul_a = $signed(qn);
      mul_b = $signed(qn);
    end else begin
      mul_a = $signed(att[term_q(LANE, ctl.term)]);
      mul_b = $signed(rates[term_r(LANE, ctl.term)]);
    end
  end

  // Floored term, step scaling sum and saturated update.
  always_comb begin
    term_val = 39'(prod >>> 25);
    ssum = ph + (pl >>> 16);
    tot = 44'($signed(att[LANE])) + 44'(scaled);
    if (tot > 44'sh0_7FFF_FFFF) begin
      sat = 32'h7FFF_FFFF;
    end else if (tot < -44'sh0_8000_0000) begin
      sat = 32'h8000_0000;
    end else begin
      sat = tot[31:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (ctl.term_mul || ctl.square) begin
      prod <= mul_a * mul_b;
      prod_neg <= term_neg(LANE, ctl.term);
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (ctl.term_add) begin
      acc <= prod_neg ? acc - 42'(term_val) : acc + 42'(term_val);
    end
    if (ctl.scale_mul) begin
      ph <= acc * $signed({1'b0, step_time[31:16]});
      pl <= acc * $signed({1'b0, step_time[15:0]});
    end
    if (ctl.scale_sum) begin
      scaled <= 43'(ssum >>> 16);
    end
    if (ctl.update) begin
      qn <= sat;
    end
  end

  assign sq = prod[62:0];

endmodule

// ===== sv/gyro_quaternion_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator
// One Euler step of attitude-quaternion integration per gyro sample.
// ----------------------------------------------------------------------------
// Each accepted gyro sample produces one attitude quaternion, normalized
// unless its norm is zero. Four lanes work on w, x, y and z side by side;
// the norm is an integer Newton square root built on a one-bit-per-cycle
// restoring divider. The time to a result grows with L, the bit length of
// the sum of squares over four (about 60 for a unit quaternion), and with
// the NORM_ITERATIONS + 1 divisions, which take most of it at the default
// of four iterations. When the norm is zero the block skips the Newton
// iterations and divisions. The next sample can be taken in the cycle
// after the result has been moved into the output register, even if it
// has not been taken yet; a result that still waits in the output
// register holds the block in its finish step. The step time register resets
// to about one millisecond and should be written only while no sample is in
// flight.
// ----------------------------------------------------------------------------
module gyro_quaternion_integrator #(
  parameter int NORM_ITERATIONS = gqi_pkg::NORM_ITERATIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,     // step_time
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,       // rate_x, rate_y, rate_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,       // att_w, att_x, att_y, att_z
  output logic [0:0]   m_tuser        // zero_norm
);
  import gqi_pkg::*;

  localparam int IW = $clog2(NORM_ITERATIONS + 1);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_DERIV     = 12'b0000_0000_0010,
    S_SCALE     = 12'b0000_0000_0100,
    S_SQUARE    = 12'b0000_0000_1000,
    S_SUM       = 12'b0000_0001_0000,
    S_CHECK     = 12'b0000_0010_0000,
    S_LEN       = 12'b0000_0100_0000,
    S_NEWT_GO   = 12'b0000_1000_0000,
    S_NEWT_WAIT = 12'b0001_0000_0000,
    S_DIV_GO    = 12'b0010_0000_0000,
    S_DIV_WAIT  = 12'b0100_0000_0000,
    S_FINISH    = 12'b1000_0000_0000
  } state_t;

  state_t            state;
  logic [1:0]        cnt;
  word_t             step_time;
  quat_t             att;
  rates_t            rates;
  lane_ctl_t         ctl;
  quat_t             qn;
  logic [62:0]       sq [4];
  logic [63:0]       pair0;
  logic [63:0]       pair1;
  logic [64:0]       total;
  logic [62:0]       s;
  logic [62:0]       t;
  logic [5:0]        len;
  logic [6:0]        len_up;
  logic [DIV_DW-1:0] n;
  logic [IW-1:0]     it;
  logic              zero;
  logic [3:0]        div_start;
  logic [3:0]        div_done;
  logic [DIV_NW-1:0] div_num [4];
  logic [DIV_NW-1:0] quo [4];
  quat_t             res;

  assign s_tready = (state == S_IDLE);

  // Step time register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_RESET;
    end else if (cfg_we) begin
      step_time <= cfg_wdata;
    end
  end

  // Lane control decoded from the sequencer state.
  always_comb begin
    ctl = '0;
    ctl.term = cnt;
    case (state)
      S_DERIV: begin
        ctl.acc_clr = (cnt == 2'd0);
        ctl.term_mul = (cnt != 2'd3);
        ctl.term_add = (cnt != 2'd0);
      end
      S_SCALE: begin
        ctl.scale_mul = (cnt == 2'd0);
        ctl.scale_sum = (cnt == 2'd1);
        ctl.update = (cnt == 2'd2);
      end
      S_SQUARE: begin
        ctl.square = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Four parallel lanes and their dividers.
  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [31:0] mag;

    gqi_lane #(
      .LANE(j)
    ) u_lane (
      .clk(clk),
      .ctl(ctl),
      .att(att),
      .rates(rates),
      .step_time(step_time),
      .qn(qn[j]),
      .sq(sq[j])
    );

    assign mag = qn[j][31] ? 32'(-qn[j]) : qn[j];

    // Lane 0 also carries the Newton quotients.
    if (j == 0) begin : g_newton
      assign div_num[j] = (state == S_NEWT_GO) ? DIV_NW'(s) : DIV_NW'({mag, 29'd0});
    end else begin : g_part
      assign div_num[j] = DIV_NW'({mag, 29'd0});
    end

    gqi_div u_div (
      .clk(clk),
      .rst(rst),
      .start(div_start[j]),
      .num(div_num[j]),
      .den(n),
      .done(div_done[j]),
      .quo(quo[j])
    );

    // Clamp the normalized part and restore its sign.
    always_comb begin
      if (qn[j][31]) begin
        res[j] = (quo[j] > DIV_NW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-quo[j][31:0]);
      end else begin
        res[j] = (quo[j] >= DIV_NW'(33'h0_8000_0000)) ? 32'h7FFF_FFFF : quo[j][31:0];
      end
    end
  end

  assign div_start[0] = (state == S_NEWT_GO) || (state == S_DIV_GO);
  assign div_start[3:1] = {3{state == S_DIV_GO}};

  assign total = 65'(pair0) + 65'(pair1);
  assign len_up = 7'(len) + 7'd1;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      m_tvalid <= 1'b0;
      att[0] <= ATT_ONE;
      att[1] <= '0;
      att[2] <= '0;
      att[3] <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DERIV;
            cnt <= '0;
          end
        end
        S_DERIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd2) begin
            state <= S_SQUARE;
            cnt <= '0;
          end
        end
        S_SQUARE: begin
          state <= S_SUM;
        end
        S_SUM: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd1) begin
            state <= S_CHECK;
            cnt <= '0;
          end
        end
        S_CHECK: begin
          state <= (s == '0) ? S_FINISH : S_LEN;
        end
        S_LEN: begin
          if (t == '0) begin
            state <= S_NEWT_GO;
          end
        end
        S_NEWT_GO: begin
          state <= S_NEWT_WAIT;
        end
        S_NEWT_WAIT: begin
          if (div_done[0]) begin
            state <= (it == IW'(NORM_ITERATIONS - 1)) ? S_DIV_GO : S_NEWT_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done[0]) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // The output register is free, or its transaction completes now.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            att <= zero ? qn : res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Rate capture and norm datapath: sum of squares, bit length, Newton iterate.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      rates <= s_tdata;
    end
    if (state == S_SUM) begin
      pair0 <= 64'(sq[0]) + 64'(sq[1]);
      pair1 <= 64'(sq[2]) + 64'(sq[3]);
      s <= total[64:2];
    end
    if (state == S_CHECK) begin
      zero <= (s == '0);
      t <= s;
      len <= '0;
      it <= '0;
    end
    if (state == S_LEN) begin
      if (t != '0) begin
        t <= t >> 1;
        len <= len + 1'b1;
      end else begin
        n <= DIV_DW'(1) << len_up[6:1];
      end
    end
    if (state == S_NEWT_WAIT && div_done[0]) begin
      n <= DIV_DW'(((DIV_DW + 1)'(n) + (DIV_DW + 1)'(quo[0][DIV_DW-1:0])) >> 1);
      it <= it + 1'b1;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= zero ? qn : res;
      m_tuser <= zero;
    end
  end

  // A divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done[0] |-> (state == S_NEWT_WAIT || state == S_DIV_WAIT))
    else $error("divider done outside a wait state");

  // The four part dividers run in lockstep.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_WAIT && div_done[0]) |-> (div_done == 4'hF))
    else $error("part dividers out of step");

  // The Newton iterate never reaches zero.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_NEWT_GO || state == S_DIV_GO) |-> (n != '0))
    else $error("zero divisor in normalization");

  // A result is presented only after the finish step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_FINISH))
    else $error("result without finish step");

endmodule
